### hw/rtl/fpds_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point divide and square-root package
// Shared types, codes and the per-stage arithmetic step of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fpds_pkg;

  // Number of fraction bits of the fixed-point format.
  localparam int FRAC_BITS = 12;

  // Dividend width: a 32-bit magnitude shifted by the fraction bits.
  localparam int DW = 32 + FRAC_BITS;
  // Root digits: the root operand has at most 31 + FRAC_BITS significant bits.
  localparam int SQS = (31 + FRAC_BITS + 1) / 2;
  // Shift that aligns the root operand to an even bit position at the top.
  localparam int SQ_SHIFT = DW - 2 * SQS;
  // Number of step stages in the pipeline.
  localparam int NS = DW;

  // Request types.
  localparam logic [1:0] REQ_IDIV = 2'd0;
  localparam logic [1:0] REQ_FDIV = 2'd1;
  localparam logic [1:0] REQ_SQRT = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_DIV0    = 2'd1;
  localparam logic [1:0] ERR_OVF     = 2'd2;
  localparam logic [1:0] ERR_NEGROOT = 2'd3;

  // Saturation limits.
  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] numerator;
    logic signed [31:0] denominator;
  } fpds_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         error_code;
  } fpds_out_t;

  // One pipeline stage: control and the partial quotient or root.
  typedef struct packed {
    logic          valid;
    logic [1:0]    req;
    logic [1:0]    err;
    logic          neg;
    logic [DW-1:0] opnd;
    logic [DW-1:0] quo;
    logic [32:0]   rem;
    logic [31:0]   den;
  } stage_t;

  // One restoring-division step (one quotient bit) or one square-root
  // step (one root bit from two operand bits).
  function automatic stage_t pipe_step(stage_t s, logic sq);
    stage_t      o;
    logic [32:0] rs;
    logic [32:0] tr;
    logic [33:0] diff;
    o = s;
    if (!sq) begin
      rs     = {s.rem[31:0], s.opnd[DW-1]};
      tr     = {1'b0, s.den};
      o.opnd = s.opnd << 1;
    end else begin
      rs     = {s.rem[30:0], s.opnd[DW-1:DW-2]};
      tr     = {s.quo[30:0], 2'b01};
      o.opnd = s.opnd << 2;
    end
    diff = {1'b0, rs} - {1'b0, tr};
    if (!diff[33]) begin
      o.rem = diff[32:0];
      o.quo = {s.quo[DW-2:0], 1'b1};
    end else begin
      o.rem = rs;
      o.quo = {s.quo[DW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/fixed_point_divide_sqrt_unit.sv
// ----------------------------------------------------------------------------
// Fixed-point divide and square-root unit
// Pipelined signed integer divide, Q20.12 divide and Q20.12 square root.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with an fpds_in_t payload; results
//   leave on out_valid/out_ready as fpds_out_t. One item is accepted per
//   cycle while the output side keeps up.
//   Each item passes an entry register, NS = 32 + FRAC_BITS step stages
//   (one quotient bit or one root bit per stage) and an output register.
//   The length of the bit-per-stage divide chain sets the pipeline depth;
//   throughput is one item per cycle when nothing stalls.
//   Divide by zero gives 0 with error 1, an out-of-range quotient saturates
//   with error 2, and a negative root operand gives 0 with error 3.
//   A synchronous active-low reset empties the pipeline and the output.
//   When the receiver holds out_ready low with a result waiting, the whole
//   pipeline freezes and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_divide_sqrt_unit
  import fpds_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire fpds_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output fpds_out_t      out_data
);

  stage_t    pipe_r [0:NS];
  stage_t    step_nxt [0:NS-1];
  stage_t    entry_nxt;
  logic      out_valid_r;
  fpds_out_t out_data_r;
  fpds_out_t out_data_nxt;
  logic      adv;

  logic        num_neg;
  logic        den_neg;
  logic [31:0] num_mag;
  logic [31:0] den_mag;

  // The pipeline moves whenever the output register is free or drained.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Entry stage: magnitudes, signs, early error checks and operand setup.
  always_comb begin
    num_neg   = in_data.numerator[31];
    den_neg   = in_data.denominator[31];
    num_mag   = num_neg ? (32'd0 - $unsigned(in_data.numerator))
                        : $unsigned(in_data.numerator);
    den_mag   = den_neg ? (32'd0 - $unsigned(in_data.denominator))
                        : $unsigned(in_data.denominator);
    entry_nxt       = '0;
    entry_nxt.valid = in_valid;
    entry_nxt.req   = in_data.req_type;
    entry_nxt.neg   = num_neg ^ den_neg;
    entry_nxt.den   = den_mag;
    entry_nxt.err   = ERR_OK;
    unique case (in_data.req_type)
      REQ_IDIV: begin
        entry_nxt.opnd = DW'(num_mag);
        if (den_mag == 32'd0) begin
          entry_nxt.err = ERR_DIV0;
        end
      end
      REQ_FDIV: begin
        entry_nxt.opnd = DW'(num_mag) << FRAC_BITS;
        if (den_mag == 32'd0) begin
          entry_nxt.err = ERR_DIV0;
        end
      end
      REQ_SQRT: begin
        entry_nxt.opnd = (DW'(num_mag) << FRAC_BITS) << SQ_SHIFT;
        if (num_neg) begin
          entry_nxt.err = ERR_NEGROOT;
        end
      end
      default: begin
        entry_nxt.opnd = '0;
      end
    endcase
  end

  // Step stages: a root finishes after SQS stages and then passes through.
  for (genvar k = 0; k < NS; k++) begin : g_step
    always_comb begin
      if ((pipe_r[k].req == REQ_SQRT) && (k >= SQS)) begin
        step_nxt[k] = pipe_r[k];
      end else begin
        step_nxt[k] = pipe_step(pipe_r[k], pipe_r[k].req == REQ_SQRT);
      end
    end
  end

  // Pipeline registers; only the valid bits are reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) begin
        pipe_r[i].valid <= 1'b0;
      end
    end else if (adv) begin
      pipe_r[0] <= entry_nxt;
      for (int i = 0; i < NS; i++) begin
        pipe_r[i+1] <= step_nxt[i];
      end
    end
  end

  // Output stage: sign, saturation and error selection.
  always_comb begin
    out_data_nxt.result_value = '0;
    out_data_nxt.error_code   = pipe_r[NS].err;
    if (pipe_r[NS].err == ERR_OK) begin
      case (pipe_r[NS].req)
        REQ_IDIV, REQ_FDIV: begin
          if (pipe_r[NS].neg && (pipe_r[NS].quo != '0)) begin
            if (pipe_r[NS].quo > DW'(NEG_LIMIT)) begin
              out_data_nxt.result_value = NEG_LIMIT;
              out_data_nxt.error_code   = ERR_OVF;
            end else begin
              out_data_nxt.result_value = 32'd0 - pipe_r[NS].quo[31:0];
            end
          end else begin
            if (pipe_r[NS].quo > DW'(POS_LIMIT)) begin
              out_data_nxt.result_value = POS_LIMIT;
              out_data_nxt.error_code   = ERR_OVF;
            end else begin
              out_data_nxt.result_value = pipe_r[NS].quo[31:0];
            end
          end
        end
        REQ_SQRT: begin
          out_data_nxt.result_value = pipe_r[NS].quo[31:0];
        end
        default: begin
          out_data_nxt.result_value = '0;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= pipe_r[NS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A divide-by-zero item always carries a zero result.
  a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.error_code == ERR_DIV0) |->
      (out_data_r.result_value == 32'd0))
    else $error("divide by zero result is not zero");

  // A negative root item always carries a zero result.
  a_negroot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.error_code == ERR_NEGROOT) |->
      (out_data_r.result_value == 32'd0))
    else $error("negative root result is not zero");

  // An overflow item is saturated to one of the limits.
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.error_code == ERR_OVF) |->
      (out_data_r.result_value == POS_LIMIT ||
       out_data_r.result_value == NEG_LIMIT))
    else $error("overflow result is not saturated");

  // A stalled output freezes the last pipeline stage.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(pipe_r[NS].valid))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
